>>> sv/ipv4hc_pkg.sv
// Shared types and constants for the IPv4 header parser and checksum checker.
// Used by ipv4hc_core and ipv4_header_parse_check_top; depends on nothing.
`default_nettype none

package ipv4hc_pkg;

	typedef enum logic [1:0] {
		KIND_HEADER       = 2'd0,
		KIND_PAYLOAD      = 2'd1,
		KIND_PAYLOAD_LAST = 2'd2
	} kind_t;

	localparam logic [3:0] MIN_HEADER_WORDS = 4'd5;
	localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;

	localparam logic [15:0] IDX_TOS      = 16'd1;
	localparam logic [15:0] IDX_LEN_HI   = 16'd2;
	localparam logic [15:0] IDX_LEN_LO   = 16'd3;
	localparam logic [15:0] IDX_ID_HI    = 16'd4;
	localparam logic [15:0] IDX_ID_LO    = 16'd5;
	localparam logic [15:0] IDX_FRAG_HI  = 16'd6;
	localparam logic [15:0] IDX_FRAG_LO  = 16'd7;
	localparam logic [15:0] IDX_TTL      = 16'd8;
	localparam logic [15:0] IDX_PROTO    = 16'd9;
	localparam logic [15:0] IDX_ADDR_LO  = 16'd12;
	localparam logic [15:0] IDX_ADDR_HI  = 16'd19;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  version;
		logic [3:0]  header_words;
		logic [7:0]  service_type;
		logic [15:0] total_length;
		logic [15:0] ident;
		logic [15:0] frag_field;
		logic [7:0]  time_to_live;
		logic [7:0]  protocol;
		logic [63:0] addresses;
		logic        checksum_ok;
		logic [7:0]  payload_byte;
	} result_t;

endpackage

`default_nettype wire

>>> sv/ipv4_header_parse_check_top.sv
// Top level of the IPv4 header parser and checksum checker: input and result registers.
// Uses ipv4hc_pkg and ipv4hc_core.
`default_nettype none

// Takes an IPv4 datagram one byte per transfer and returns one header summary after
// the last header byte, then one result per payload byte up to the total length.
// A byte is accepted in every cycle unless the result side stalls; each byte is
// held in the input register and any result it yields is then captured in the
// result register, so throughput is one byte per cycle, limited only by the
// result side stalling. A header length below five words is treated as five, and
// start_flag forces a byte to begin a new datagram.
module ipv4_header_parse_check_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        start_flag,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [1:0]       kind,
	output logic [3:0]       version,
	output logic [3:0]       header_words,
	output logic [7:0]       service_type,
	output logic [15:0]      total_length,
	output logic [15:0]      ident,
	output logic [15:0]      frag_field,
	output logic [7:0]       time_to_live,
	output logic [7:0]       protocol,
	output logic [63:0]      addresses,
	output logic             checksum_ok,
	output logic [7:0]       payload_byte
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                start_s1;
	logic                out_free;
	logic                fire;
	logic                emit;
	ipv4hc_pkg::result_t res;
	ipv4hc_pkg::result_t res_q;
	logic                res_valid_q;

	assign out_free = !res_valid_q || !result_stall;
	assign fire = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			byte_s1 <= data_byte;
			start_s1 <= start_flag;
		end
	end

	ipv4hc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.data_byte  (byte_s1),
		.start_flag (start_s1),
		.emit       (emit),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_q <= res;
		end
	end

	assign result_valid = res_valid_q;
	assign kind = res_q.kind;
	assign version = res_q.version;
	assign header_words = res_q.header_words;
	assign service_type = res_q.service_type;
	assign total_length = res_q.total_length;
	assign ident = res_q.ident;
	assign frag_field = res_q.frag_field;
	assign time_to_live = res_q.time_to_live;
	assign protocol = res_q.protocol;
	assign addresses = res_q.addresses;
	assign checksum_ok = res_q.checksum_ok;
	assign payload_byte = res_q.payload_byte;

endmodule

`default_nettype wire

>>> sv/ipv4hc_core.sv
// Datagram state and per-byte parse logic: header capture, folded checksum, payload count.
// Uses ipv4hc_pkg; instantiated by ipv4_header_parse_check_top.
`default_nettype none

module ipv4hc_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [7:0]        data_byte,
	input  wire logic              start_flag,
	output logic                   emit,
	output ipv4hc_pkg::result_t    res
);

	logic [15:0] byte_index_q;
	logic [15:0] sum_q;
	logic [7:0]  hold_q;
	logic [7:0]  first_q;
	logic [7:0]  tos_q;
	logic [15:0] length_q;
	logic [15:0] ident_q;
	logic [15:0] frag_q;
	logic [7:0]  ttl_q;
	logic [7:0]  proto_q;
	logic [63:0] addr_q;

	logic [15:0] idx;
	logic [7:0]  first_d;
	logic [3:0]  hwords;
	logic [5:0]  hbytes;
	logic        in_hdr;
	logic        hdr_end;
	logic [16:0] sum_raw;
	logic [15:0] sum_base;
	logic [15:0] sum_d;
	logic [7:0]  hold_d;
	logic [7:0]  tos_d;
	logic [15:0] length_d;
	logic [15:0] ident_d;
	logic [15:0] frag_d;
	logic [7:0]  ttl_d;
	logic [7:0]  proto_d;
	logic [63:0] addr_d;
	logic [16:0] idx_inc;
	logic        pay_last;
	logic [15:0] byte_index_d;

	always_comb begin
		idx = start_flag ? 16'd0 : byte_index_q;
		first_d = (idx == 16'd0) ? data_byte : first_q;
		hwords = (first_d[3:0] < ipv4hc_pkg::MIN_HEADER_WORDS) ?
			ipv4hc_pkg::MIN_HEADER_WORDS : first_d[3:0];
		hbytes = {hwords, 2'b00};
		in_hdr = idx < {10'd0, hbytes};
		hdr_end = in_hdr && (idx == {10'd0, hbytes - 6'd1});
		idx_inc = {1'b0, idx} + 17'd1;
		pay_last = idx_inc >= {1'b0, length_q};

		sum_base = (idx == 16'd0) ? 16'd0 : sum_q;
		sum_raw = {1'b0, sum_base} + {1'b0, hold_q, data_byte};
		sum_d = sum_base;
		hold_d = hold_q;
		if (in_hdr) begin
			if (idx[0]) begin
				sum_d = sum_raw[16] ? (sum_raw[15:0] + 16'd1) : sum_raw[15:0];
			end else begin
				hold_d = data_byte;
			end
		end

		tos_d = tos_q;
		length_d = length_q;
		ident_d = ident_q;
		frag_d = frag_q;
		ttl_d = ttl_q;
		proto_d = proto_q;
		addr_d = addr_q;
		if (in_hdr) begin
			case (idx)
				ipv4hc_pkg::IDX_TOS:     tos_d = data_byte;
				ipv4hc_pkg::IDX_LEN_HI:  length_d = {data_byte, length_q[7:0]};
				ipv4hc_pkg::IDX_LEN_LO:  length_d = {length_q[15:8], data_byte};
				ipv4hc_pkg::IDX_ID_HI:   ident_d = {data_byte, ident_q[7:0]};
				ipv4hc_pkg::IDX_ID_LO:   ident_d = {ident_q[15:8], data_byte};
				ipv4hc_pkg::IDX_FRAG_HI: frag_d = {data_byte, frag_q[7:0]};
				ipv4hc_pkg::IDX_FRAG_LO: frag_d = {frag_q[15:8], data_byte};
				ipv4hc_pkg::IDX_TTL:     ttl_d = data_byte;
				ipv4hc_pkg::IDX_PROTO:   proto_d = data_byte;
				default: begin
					if (idx >= ipv4hc_pkg::IDX_ADDR_LO && idx <= ipv4hc_pkg::IDX_ADDR_HI) begin
						addr_d = {addr_q[55:0], data_byte};
					end
				end
			endcase
		end

		if (in_hdr) begin
			if (hdr_end && !(length_d > {10'd0, hbytes})) begin
				byte_index_d = 16'd0;
			end else begin
				byte_index_d = idx_inc[15:0];
			end
		end else begin
			byte_index_d = pay_last ? 16'd0 : idx_inc[15:0];
		end
	end

	always_comb begin
		res = '0;
		emit = 1'b0;
		if (in_hdr) begin
			emit = hdr_end;
			res.kind = ipv4hc_pkg::KIND_HEADER;
			res.version = first_d[7:4];
			res.header_words = first_d[3:0];
			res.service_type = tos_d;
			res.total_length = length_d;
			res.ident = ident_d;
			res.frag_field = frag_d;
			res.time_to_live = ttl_d;
			res.protocol = proto_d;
			res.addresses = addr_d;
			res.checksum_ok = sum_d == ipv4hc_pkg::SUM_ALL_ONES;
		end else begin
			emit = 1'b1;
			res.kind = pay_last ? ipv4hc_pkg::KIND_PAYLOAD_LAST : ipv4hc_pkg::KIND_PAYLOAD;
			res.payload_byte = data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			sum_q <= '0;
			hold_q <= '0;
			first_q <= '0;
			tos_q <= '0;
			length_q <= '0;
			ident_q <= '0;
			frag_q <= '0;
			ttl_q <= '0;
			proto_q <= '0;
			addr_q <= '0;
		end else if (fire) begin
			byte_index_q <= byte_index_d;
			sum_q <= sum_d;
			hold_q <= hold_d;
			first_q <= first_d;
			tos_q <= tos_d;
			length_q <= length_d;
			ident_q <= ident_d;
			frag_q <= frag_d;
			ttl_q <= ttl_d;
			proto_q <= proto_d;
			addr_q <= addr_d;
		end
	end

endmodule

`default_nettype wire
